### design/assert_macros.svh
// assertion helpers for the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// implication whose consequent is checked at the next clock
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/sws_pkg.sv
// ---------------------------------------------------------------------------
// sws_pkg
// types and constants of the sliding window sender
// ---------------------------------------------------------------------------
package sws_pkg;

    localparam logic [1:0] CMD_OFFER = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_TIMER = 2'd2;
    localparam logic [1:0] CMD_SEND  = 2'd3;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_RESEND  = 3'd1;
    localparam logic [2:0] MODE_TIMEOUT = 3'd2;
    localparam logic [2:0] MODE_WAIT    = 3'd3;
    localparam logic [2:0] MODE_END     = 3'd4;

    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_RESTART = 2'd2;
    localparam logic [1:0] TMR_STOP    = 2'd3;

    localparam logic [2:0] REG_MAX_SEGMENT = 3'd0;
    localparam logic [2:0] REG_ALPHA       = 3'd1;
    localparam logic [2:0] REG_BETA        = 3'd2;
    localparam logic [2:0] REG_INIT_TO     = 3'd3;
    localparam logic [2:0] REG_INIT_WIN    = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [16:0] offered_length;
        logic [31:0] ack_number;
        logic [31:0] peer_seq;
        logic [15:0] peer_window;
        logic [31:0] now_us;
    } sws_in_t;

    typedef struct packed {
        logic        segment_valid;
        logic [15:0] segment_offset;
        logic [10:0] segment_length;
        logic [31:0] segment_seq;
        logic [31:0] segment_ack;
        logic [1:0]  timer_action;
        logic [31:0] timeout_value_us;
        logic [16:0] accepted_length;
        logic [2:0]  window_mode;
    } sws_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic rtt_a;
        logic rtt_b;
        logic rtt_c;
    } sws_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_rtt;
    } sws_stat_t;

endpackage

### design/sws_ctrl.sv
// ---------------------------------------------------------------------------
// sws_ctrl
// sequencer: load request, update state, run rtt steps if needed, present result
// ---------------------------------------------------------------------------
module sws_ctrl import sws_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic      out_fire,
    input  sws_stat_t stat,
    output sws_cmd_t  cmd,
    output logic      in_ready,
    output logic      out_valid
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_RA   = 3'd2;
    localparam logic [2:0] ST_RB   = 3'd3;
    localparam logic [2:0] ST_RC   = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.load = in_fire;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_STEP;
            ST_STEP: begin
                cmd.step = 1'b1;
                state_next = stat.need_rtt ? ST_RA : ST_OUT;
            end
            ST_RA: begin
                cmd.rtt_a = 1'b1;
                state_next = ST_RB;
            end
            ST_RB: begin
                cmd.rtt_b = 1'b1;
                state_next = ST_RC;
            end
            ST_RC: begin
                cmd.rtt_c = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

### design/sws_datapath.sv
// ---------------------------------------------------------------------------
// sws_datapath
// window counters, segment selection and rtt estimator on shared multipliers
// ---------------------------------------------------------------------------
module sws_datapath import sws_pkg::*; #(
    parameter int BUFFER_BYTES  = 65536,
    parameter int DUP_ACK_LIMIT = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  sws_cmd_t    cmd,
    output sws_stat_t   stat,
    input  sws_in_t     req,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output sws_out_t    res
);

    localparam int BUF_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [BUF_W-1:0] BUF_SPAN = BUF_W'(BUFFER_BYTES);
    localparam logic [1:0] DUP_LIM = 2'(DUP_ACK_LIMIT);

    sws_in_t  req_reg;
    sws_out_t res_reg, res_next;

    logic [10:0] max_seg_reg;
    logic [8:0]  alpha_reg, beta_reg;
    logic [31:0] init_to_reg;
    logic [15:0] init_win_reg;

    logic [31:0] acked_seq_reg, peer_last_reg, acked_cnt_reg, sent_cnt_reg, end_cnt_reg;
    logic [15:0] win_reg;
    logic [2:0]  mode_reg;
    logic [1:0]  dup_reg;
    logic        timer_reg, pend_reg;
    logic [31:0] sseq_reg, stime_reg, est_reg, dev_reg, to_reg;
    logic        need_rtt_reg;

    logic [31:0] acked_seq_next, peer_last_next, acked_cnt_next, sent_cnt_next, end_cnt_next;
    logic [15:0] win_next;
    logic [2:0]  mode_next, m;
    logic [1:0]  dup_next;
    logic        timer_next, pend_next, need_rtt_next;
    logic [31:0] sseq_next, stime_next;

    logic [31:0] delta, outst, avail, sample_reg, diff_reg, est_new;
    logic [BUF_W-1:0] start, room;
    logic [16:0] take;
    logic [10:0] seg, adv, len;
    logic [8:0]  ga, gb;
    logic [40:0] acc_reg;
    logic [40:0] prod0, prod1, prod_sum;

    assign ga  = (alpha_reg > 9'd256) ? 9'd256 : alpha_reg;
    assign gb  = (beta_reg > 9'd256) ? 9'd256 : beta_reg;
    assign seg = (max_seg_reg == 11'd0) ? 11'd1 :
                 (max_seg_reg > 11'd1500) ? 11'd1500 : max_seg_reg;

    always_comb begin
        acked_seq_next = acked_seq_reg; peer_last_next = peer_last_reg;
        acked_cnt_next = acked_cnt_reg; sent_cnt_next = sent_cnt_reg;
        end_cnt_next = end_cnt_reg; win_next = win_reg; mode_next = mode_reg;
        dup_next = dup_reg; timer_next = timer_reg; pend_next = pend_reg;
        sseq_next = sseq_reg; stime_next = stime_reg; need_rtt_next = 1'b0;
        res_next = '0;
        delta = req_reg.ack_number - acked_seq_reg;
        outst = sent_cnt_reg - acked_cnt_reg;
        avail = end_cnt_reg - sent_cnt_reg;
        start = BUF_W'(end_cnt_reg % BUFFER_BYTES);
        room  = BUF_SPAN - start;
        take  = (32'(room) < 32'(req_reg.offered_length)) ? 17'(room)
                                                          : req_reg.offered_length;
        adv = seg; len = 11'd0; m = mode_reg;
        case (req_reg.command)
            CMD_OFFER: begin
                if (req_reg.offered_length != 17'd0 && end_cnt_reg == acked_cnt_reg) begin
                    end_cnt_next = end_cnt_reg + 32'(take);
                    res_next.accepted_length = take;
                end
            end
            CMD_ACK: begin
                if (delta != 32'd0 && !delta[31]) begin
                    if (delta <= outst) begin
                        acked_seq_next = req_reg.ack_number;
                        if ((req_reg.peer_seq - peer_last_reg - 32'd1) < 32'h7FFF_FFFF)
                            peer_last_next = req_reg.peer_seq;
                        win_next = req_reg.peer_window;
                        acked_cnt_next = acked_cnt_reg + delta;
                        mode_next = MODE_NORMAL;
                        timer_next = (acked_cnt_next != sent_cnt_reg);
                        res_next.timer_action = timer_next ? TMR_RESTART : TMR_STOP;
                        if (pend_reg && req_reg.ack_number == sseq_reg) begin
                            need_rtt_next = 1'b1;
                            pend_next = 1'b0;
                        end
                        dup_next = 2'd0;
                    end
                end else begin
                    dup_next = dup_reg + 2'd1;
                    if (dup_next >= DUP_LIM) begin
                        mode_next = MODE_RESEND;
                        dup_next = 2'd0;
                    end
                end
            end
            CMD_TIMER: begin
                if (timer_reg) begin
                    timer_next = 1'b0;
                    mode_next = MODE_TIMEOUT;
                end
            end
            default: begin
                if (end_cnt_reg != acked_cnt_reg) begin
                    if (end_cnt_reg == sent_cnt_reg && m == MODE_NORMAL) m = MODE_END;
                    if (m == MODE_NORMAL && ({1'b0, outst} + 33'(seg)) > 33'(win_reg)) begin
                        if (win_reg == 16'd0) adv = 11'd1;
                        else if (win_reg < 16'(seg)) adv = win_reg[10:0];
                        else m = MODE_WAIT;
                    end
                    res_next.window_mode = m;
                    mode_next = MODE_NORMAL;
                    if (m == MODE_NORMAL) begin
                        len = (avail < 32'(adv)) ? avail[10:0] : adv;
                        if (!timer_reg) begin
                            timer_next = 1'b1;
                            res_next.timer_action = TMR_START;
                        end
                        res_next.segment_valid = 1'b1;
                        res_next.segment_offset = 16'(sent_cnt_reg % BUFFER_BYTES);
                        res_next.segment_seq = acked_seq_reg + outst;
                        sent_cnt_next = sent_cnt_reg + 32'(len);
                    end else if ((m == MODE_RESEND || m == MODE_TIMEOUT) && outst != 0) begin
                        len = (outst < 32'(adv)) ? outst[10:0] : adv;
                        timer_next = 1'b1;
                        res_next.timer_action = TMR_RESTART;
                        res_next.segment_valid = 1'b1;
                        res_next.segment_offset = 16'(acked_cnt_reg % BUFFER_BYTES);
                        res_next.segment_seq = acked_seq_reg;
                    end
                    res_next.segment_length = len;
                    res_next.segment_ack = res_next.segment_valid ? peer_last_reg : 32'd0;
                    if (res_next.segment_valid && !pend_reg) begin
                        pend_next = 1'b1;
                        sseq_next = res_next.segment_seq + 32'(len);
                        stime_next = req_reg.now_us;
                    end
                end
            end
        endcase
        if (req_reg.command != CMD_SEND || end_cnt_reg == acked_cnt_reg)
            res_next.window_mode = mode_next;
        res_next.timeout_value_us = to_reg;
    end

    // shared multiplier operands per rtt step
    assign est_new = acc_reg[39:8];
    always_comb begin
        if (cmd.rtt_a) begin
            prod0 = 41'(9'd256 - ga) * 41'(est_reg);
            prod1 = 41'(ga) * 41'(sample_reg);
        end else begin
            prod0 = 41'(9'd256 - gb) * 41'(dev_reg);
            prod1 = 41'(gb) * 41'(diff_reg);
        end
    end
    assign prod_sum = prod0 + prod1;

    logic [34:0] to_sum;
    logic [31:0] to_shown;
    assign to_sum = 35'(est_reg) + {1'b0, prod_sum[39:8], 2'b00};
    assign to_shown = (to_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : to_sum[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= req;
        if (cmd.rtt_a) acc_reg <= prod_sum;
        if (cmd.rtt_b) begin
            diff_reg <= (sample_reg >= est_new) ? sample_reg - est_new : est_new - sample_reg;
        end
        if (cmd.step) begin
            res_reg <= res_next;
            sample_reg <= req_reg.now_us - stime_reg;
        end
        if (cmd.rtt_c) res_reg.timeout_value_us <= to_shown;
        if (!aresetn) begin
            max_seg_reg <= 11'd1400; alpha_reg <= 9'd32; beta_reg <= 9'd64;
            init_to_reg <= 32'd1000000; init_win_reg <= 16'd1400;
            acked_seq_reg <= '0; peer_last_reg <= '0; acked_cnt_reg <= '0;
            sent_cnt_reg <= '0; end_cnt_reg <= '0; win_reg <= 16'd1400;
            mode_reg <= MODE_NORMAL; dup_reg <= '0; timer_reg <= 1'b0; pend_reg <= 1'b0;
            sseq_reg <= '0; stime_reg <= '0; est_reg <= 32'd1000000; dev_reg <= '0;
            to_reg <= 32'd1000000; need_rtt_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAX_SEGMENT: max_seg_reg <= cfg_data[10:0];
                    REG_ALPHA: alpha_reg <= cfg_data[8:0];
                    REG_BETA: beta_reg <= cfg_data[8:0];
                    REG_INIT_TO: begin
                        init_to_reg <= cfg_data; est_reg <= cfg_data; to_reg <= cfg_data;
                    end
                    REG_INIT_WIN: begin
                        init_win_reg <= cfg_data[15:0]; win_reg <= cfg_data[15:0];
                    end
                    default: ;
                endcase
            end
            if (cmd.step) begin
                acked_seq_reg <= acked_seq_next; peer_last_reg <= peer_last_next;
                acked_cnt_reg <= acked_cnt_next; sent_cnt_reg <= sent_cnt_next;
                end_cnt_reg <= end_cnt_next; win_reg <= win_next; mode_reg <= mode_next;
                dup_reg <= dup_next; timer_reg <= timer_next; pend_reg <= pend_next;
                sseq_reg <= sseq_next; stime_reg <= stime_next;
                need_rtt_reg <= need_rtt_next;
            end
            if (cmd.rtt_b) est_reg <= est_new;
            if (cmd.rtt_c) begin
                dev_reg <= prod_sum[39:8];
                to_reg <= to_shown;
            end
        end
    end

    always_comb begin
        res = res_reg;
    end

    assign stat.need_rtt = need_rtt_next;

    logic unused_ok;
    assign unused_ok = ^{init_to_reg, init_win_reg, need_rtt_reg, acc_reg[40],
                         acc_reg[7:0], prod_sum[40], prod_sum[7:0]};

endmodule

### design/sliding_window_sender.sv
// a request is registered; the step state then updates the window and the result
// an ack closing an rtt sample then runs the rtt steps on the shared multipliers
// the next request is taken once the result has been delivered
// reset: synchronous active-low aresetn, state and config registers get defaults
// ---------------------------------------------------------------------------
// sliding_window_sender
// sender side of a sliding window with retransmission and rtt timeout
// ---------------------------------------------------------------------------
module sliding_window_sender import sws_pkg::*; #(
    parameter int BUFFER_BYTES  = 65536,
    parameter int DUP_ACK_LIMIT = 3
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command, offered_length, ack_number, peer_seq, peer_window, now_us, pad
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // segment_valid, segment_offset, segment_length, segment_seq, segment_ack,
    // timer_action, timeout_value_us, accepted_length, window_mode, pad
    output logic [151:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    sws_cmd_t  cmd;
    sws_stat_t stat;
    sws_in_t   req;
    sws_out_t  res;
    logic      in_fire, out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    assign req.command        = s_tdata[1:0];
    assign req.offered_length = s_tdata[18:2];
    assign req.ack_number     = s_tdata[50:19];
    assign req.peer_seq       = s_tdata[82:51];
    assign req.peer_window    = s_tdata[98:83];
    assign req.now_us         = s_tdata[130:99];

    assign m_tdata = {6'd0, res.window_mode, res.accepted_length, res.timeout_value_us,
                      res.timer_action, res.segment_ack, res.segment_seq,
                      res.segment_length, res.segment_offset, res.segment_valid};

    sws_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
    );

    sws_datapath #(.BUFFER_BYTES(BUFFER_BYTES), .DUP_ACK_LIMIT(DUP_ACK_LIMIT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .req(req),
        .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .res(res)
    );

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_take_busy, aclk, aresetn, m_tvalid, !s_tready, "input taken while busy")
    `ASSERT_NEXT(a_busy_after_take, aclk, aresetn, in_fire, !s_tready, "ready after take")
    `ASSERT_NEXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")

endmodule

### tb/sv/sliding_window_sender_tb.sv
// ---------------------------------------------------------------------------
// sliding_window_sender_tb
// drives offer, ack, timer and send requests into the sliding window sender,
// predicts every result from a model of the window state and compares them
// field by field, across several register settings and stall patterns
// ---------------------------------------------------------------------------
module sliding_window_sender_tb;
    import sws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF = 65536;

    typedef struct {
        logic [31:0] acked_seq, peer_last, acked_cnt, sent_cnt, end_cnt;
        logic [15:0] pwin;
        logic [2:0]  mode;
        logic [1:0]  dup;
        logic        tmr_run, samp_pend;
        logic [31:0] samp_seq, samp_time, est, dev, tmo;
    } win_state_t;

    typedef struct {
        logic [10:0] max_seg;
        logic [8:0]  alpha, beta;
        logic [31:0] init_to;
        logic [15:0] init_win;
    } win_cfg_t;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [135:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0;
    logic [151:0] m_tdata;
    logic cfg_valid = 0, cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    sws_in_t  request_q[$];
    sws_out_t segment_exp_q[$];
    win_state_t gen_st, chk_st;
    win_cfg_t gen_cfg, chk_cfg;
    int fails = 0;
    int snd_idle = 36, rcv_idle = 72;
    int hold_req = 0, hold_cnt = 0;
    bit s_taken = 0;

    sliding_window_sender dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    initial begin
        #2ms;
        $display("sliding_window_sender_tb NOT OK");
        $finish;
    end

    function automatic void win_reset(output win_state_t s, output win_cfg_t c);
        c.max_seg = 11'd1400; c.alpha = 9'd32; c.beta = 9'd64;
        c.init_to = 32'd1000000; c.init_win = 16'd1400;
        s.acked_seq = 0; s.peer_last = 0; s.acked_cnt = 0; s.sent_cnt = 0; s.end_cnt = 0;
        s.pwin = c.init_win; s.mode = MODE_NORMAL; s.dup = 0;
        s.tmr_run = 0; s.samp_pend = 0; s.samp_seq = 0; s.samp_time = 0;
        s.est = c.init_to; s.dev = 0; s.tmo = c.init_to;
    endfunction

    function automatic void win_config(inout win_state_t s, inout win_cfg_t c,
                                       input logic [2:0] idx, input logic [31:0] v);
        case (idx)
            REG_MAX_SEGMENT: c.max_seg = v[10:0];
            REG_ALPHA: c.alpha = v[8:0];
            REG_BETA: c.beta = v[8:0];
            REG_INIT_TO: begin
                c.init_to = v; s.est = v; s.tmo = v;
            end
            REG_INIT_WIN: begin
                c.init_win = v[15:0]; s.pwin = v[15:0];
            end
            default: ;
        endcase
    endfunction

    function automatic void put_segment(inout win_state_t s, inout sws_out_t o,
                                        input logic [31:0] cnt, len, seq, now);
        o.segment_valid = 1;
        o.segment_offset = 16'(cnt % BUF);
        o.segment_length = len[10:0];
        o.segment_seq = seq;
        o.segment_ack = s.peer_last;
        if (!s.samp_pend) begin
            s.samp_pend = 1; s.samp_seq = seq + len; s.samp_time = now;
        end
    endfunction

    function automatic sws_out_t win_step(inout win_state_t s, input win_cfg_t c,
                                          input sws_in_t x);
        sws_out_t o;
        logic [31:0] delta, outst, start, room, take, seg, adv, avail, len, sample;
        logic [63:0] a, b, est, diff, dev, to;
        logic [2:0] shown;
        o = '0;
        outst = s.sent_cnt - s.acked_cnt;
        case (x.command)
            CMD_OFFER: begin
                if (x.offered_length != 0 && s.end_cnt == s.acked_cnt) begin
                    start = s.end_cnt % BUF;
                    room = BUF - start;
                    take = (32'(x.offered_length) < room) ? 32'(x.offered_length) : room;
                    s.end_cnt += take;
                    o.accepted_length = take[16:0];
                end
                shown = s.mode;
            end
            CMD_ACK: begin
                delta = x.ack_number - s.acked_seq;
                if (delta != 0 && !delta[31]) begin
                    if (delta <= outst) begin
                        s.acked_seq = x.ack_number;
                        if (32'(x.peer_seq - s.peer_last) - 32'd1 < 32'h7fffffff)
                            s.peer_last = x.peer_seq;
                        s.pwin = x.peer_window;
                        s.acked_cnt += delta;
                        s.mode = MODE_NORMAL;
                        if (s.acked_cnt != s.sent_cnt) begin
                            s.tmr_run = 1; o.timer_action = TMR_RESTART;
                        end else begin
                            s.tmr_run = 0; o.timer_action = TMR_STOP;
                        end
                        if (s.samp_pend && x.ack_number == s.samp_seq) begin
                            a = (c.alpha > 256) ? 64'd256 : 64'(c.alpha);
                            b = (c.beta > 256) ? 64'd256 : 64'(c.beta);
                            sample = x.now_us - s.samp_time;
                            est = ((256 - a) * 64'(s.est) + a * 64'(sample)) >> 8;
                            diff = (64'(sample) >= est) ? 64'(sample) - est
                                                        : est - 64'(sample);
                            dev = ((256 - b) * 64'(s.dev) + b * diff) >> 8;
                            to = est + 4 * dev;
                            s.est = est[31:0];
                            s.dev = dev[31:0];
                            s.tmo = (to > 64'hffffffff) ? 32'hffffffff : to[31:0];
                            s.samp_pend = 0;
                        end
                        s.dup = 0;
                    end
                end else begin
                    s.dup = s.dup + 2'd1;
                    if (s.dup >= 2'd3) begin
                        s.mode = MODE_RESEND; s.dup = 0;
                    end
                end
                shown = s.mode;
            end
            CMD_TIMER: begin
                if (s.tmr_run) begin
                    s.tmr_run = 0; s.mode = MODE_TIMEOUT;
                end
                shown = s.mode;
            end
            default: begin
                if (s.end_cnt == s.acked_cnt) begin
                    shown = s.mode;
                end else begin
                    seg = (c.max_seg == 0) ? 32'd1 : (c.max_seg > 1500) ? 32'd1500
                                                                       : 32'(c.max_seg);
                    adv = seg;
                    if (s.end_cnt == s.sent_cnt && s.mode == MODE_NORMAL)
                        s.mode = MODE_END;
                    if (s.mode == MODE_NORMAL && 64'(outst) + 64'(seg) > 64'(s.pwin)) begin
                        if (s.pwin == 0) adv = 1;
                        else if (32'(s.pwin) < seg) adv = 32'(s.pwin);
                        else s.mode = MODE_WAIT;
                    end
                    shown = s.mode;
                    if (s.mode == MODE_NORMAL) begin
                        avail = s.end_cnt - s.sent_cnt;
                        len = (avail < adv) ? avail : adv;
                        if (!s.tmr_run) begin
                            s.tmr_run = 1; o.timer_action = TMR_START;
                        end
                        put_segment(s, o, s.sent_cnt, len, s.acked_seq + outst, x.now_us);
                        s.sent_cnt += len;
                    end else if (s.mode == MODE_RESEND || s.mode == MODE_TIMEOUT) begin
                        if (outst != 0) begin
                            len = (outst < adv) ? outst : adv;
                            s.tmr_run = 1; o.timer_action = TMR_RESTART;
                            put_segment(s, o, s.acked_cnt, len, s.acked_seq, x.now_us);
                        end
                        s.mode = MODE_NORMAL;
                    end else begin
                        s.mode = MODE_NORMAL;
                    end
                end
            end
        endcase
        o.timeout_value_us = s.tmo;
        o.window_mode = shown;
        return o;
    endfunction

    // request bus monitor and result checker
    task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s expected %0h actual %0h", name, e, a);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        sws_in_t x;
        sws_out_t e, a;
        s_taken = s_tvalid && s_tready;
        if (s_taken) begin
            x.command = s_tdata[1:0];
            x.offered_length = s_tdata[18:2];
            x.ack_number = s_tdata[50:19];
            x.peer_seq = s_tdata[82:51];
            x.peer_window = s_tdata[98:83];
            x.now_us = s_tdata[130:99];
            segment_exp_q.push_back(win_step(chk_st, chk_cfg, x));
        end
        if (m_tvalid && m_tready) begin
            a.segment_valid = m_tdata[0];
            a.segment_offset = m_tdata[16:1];
            a.segment_length = m_tdata[27:17];
            a.segment_seq = m_tdata[59:28];
            a.segment_ack = m_tdata[91:60];
            a.timer_action = m_tdata[93:92];
            a.timeout_value_us = m_tdata[125:94];
            a.accepted_length = m_tdata[142:126];
            a.window_mode = m_tdata[145:143];
            if (segment_exp_q.size() == 0) begin
                $error("result with no request pending");
                fails++;
            end else begin
                e = segment_exp_q.pop_front();
                cmp("segment_valid", 32'(e.segment_valid), 32'(a.segment_valid));
                cmp("segment_offset", 32'(e.segment_offset), 32'(a.segment_offset));
                cmp("segment_length", 32'(e.segment_length), 32'(a.segment_length));
                cmp("segment_seq", e.segment_seq, a.segment_seq);
                cmp("segment_ack", e.segment_ack, a.segment_ack);
                cmp("timer_action", 32'(e.timer_action), 32'(a.timer_action));
                cmp("timeout_value_us", e.timeout_value_us, a.timeout_value_us);
                cmp("accepted_length", 32'(e.accepted_length), 32'(a.accepted_length));
                cmp("window_mode", 32'(e.window_mode), 32'(a.window_mode));
            end
        end
    end

    // request driver
    always @(negedge aclk) begin
        sws_in_t x;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (request_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
                x = request_q.pop_front();
                s_tdata <= {5'b0, x.now_us, x.peer_window, x.peer_seq, x.ack_number,
                            x.offered_length, x.command};
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic push_req(sws_in_t x);
        void'(win_step(gen_st, gen_cfg, x));
        request_q.push_back(x);
    endtask

    function automatic sws_in_t mk(logic [1:0] c, logic [16:0] off, logic [31:0] ack,
                                   logic [31:0] ps, logic [15:0] pw, logic [31:0] now);
        sws_in_t x;
        x.command = c; x.offered_length = off; x.ack_number = ack;
        x.peer_seq = ps; x.peer_window = pw; x.now_us = now;
        return x;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        @(negedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        win_config(gen_st, gen_cfg, idx, v);
        win_config(chk_st, chk_cfg, idx, v);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        wait (request_q.size() == 0 && !s_tvalid && segment_exp_q.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_req();
        sws_in_t x;
        logic [31:0] outst, now;
        int r;
        r = $urandom_range(99);
        outst = gen_st.sent_cnt - gen_st.acked_cnt;
        now = gen_st.samp_time + $urandom_range(0, 5000);
        if (r < 10) begin
            x = mk(2'($urandom_range(3)), 17'($urandom_range(0, 131071)), $urandom, $urandom,
                   16'($urandom_range(0, 65535)), $urandom);
        end else if (r < 30) begin
            if (gen_st.end_cnt != gen_st.acked_cnt && $urandom_range(3) != 0)
                x = mk(CMD_SEND, 0, 0, 0, 0, now);
            else
                x = mk(CMD_OFFER, ($urandom_range(9) == 0) ? 17'd65536
                                                           : 17'($urandom_range(1, 6000)),
                       0, 0, 0, now);
        end else if (r < 62) begin
            x = mk(CMD_SEND, 0, 0, 0, 0, now);
        end else if (r < 92) begin
            x = mk(CMD_ACK, 0, 0, gen_st.peer_last + $urandom_range(0, 3000) - 1000,
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1500, 65535)),
                   now);
            if (gen_st.samp_pend && $urandom_range(1) == 0)
                x.ack_number = gen_st.samp_seq;
            else if ($urandom_range(4) == 0)
                x.ack_number = gen_st.acked_seq - $urandom_range(0, 3);
            else
                x.ack_number = gen_st.acked_seq + $urandom_range(0, outst);
        end else begin
            x = mk(CMD_TIMER, 0, 0, 0, 0, now);
        end
        push_req(x);
    endtask

    initial begin
        win_reset(gen_st, gen_cfg);
        win_reset(chk_st, chk_cfg);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed requests from reset
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 0));
        push_req(mk(CMD_OFFER, 0, 32'hffffffff, 32'hffffffff, 16'hffff, 32'hffffffff));
        push_req(mk(CMD_TIMER, 0, 0, 0, 0, 0));
        push_req(mk(CMD_OFFER, 17'd3000, 0, 0, 0, 0));
        push_req(mk(CMD_OFFER, 17'd100, 0, 0, 0, 0));
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 32'd10));
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 32'd20));
        push_req(mk(CMD_ACK, 0, 32'd5000, 0, 0, 32'd30));
        push_req(mk(CMD_ACK, 0, 32'd1400, 32'd77, 16'd0, 32'd500));
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 32'd510));
        push_req(mk(CMD_ACK, 0, 32'd1400, 0, 0, 0));
        push_req(mk(CMD_ACK, 0, 32'd1000, 0, 0, 0));
        push_req(mk(CMD_ACK, 0, 32'd1400, 0, 0, 0));
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 32'd600));
        push_req(mk(CMD_TIMER, 0, 0, 0, 0, 0));
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 32'd700));
        push_req(mk(CMD_ACK, 0, 32'd1401, 32'h80000000, 16'd700, 32'd900));
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 32'd910));
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 32'd920));
        push_req(mk(CMD_ACK, 0, 32'd3000, 32'd5, 16'hffff, 32'hffffffff));
        push_req(mk(CMD_SEND, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                1: begin
                    reg_write(REG_MAX_SEGMENT, 32'd1);
                    reg_write(REG_ALPHA, 32'd0);
                    reg_write(REG_BETA, 32'd0);
                    reg_write(REG_INIT_TO, 32'd1);
                    reg_write(REG_INIT_WIN, 32'd0);
                end
                2: begin
                    reg_write(REG_MAX_SEGMENT, 32'd2047);
                    reg_write(REG_ALPHA, 32'd511);
                    reg_write(REG_BETA, 32'd256);
                    reg_write(REG_INIT_TO, 32'hffffffff);
                    reg_write(REG_INIT_WIN, 32'hffff);
                end
                3: begin
                    reg_write(REG_MAX_SEGMENT, 32'd0);
                    reg_write(REG_ALPHA, 32'd256);
                    reg_write(REG_BETA, 32'd511);
                    reg_write(REG_INIT_WIN, 32'd600);
                end
                4: begin
                    reg_write(REG_MAX_SEGMENT, 32'd1500);
                    reg_write(REG_ALPHA, $urandom_range(0, 511));
                    reg_write(REG_BETA, $urandom_range(0, 511));
                    reg_write(REG_INIT_TO, $urandom);
                    reg_write(REG_INIT_WIN, $urandom_range(0, 65535));
                end
                5: begin
                    reg_write(REG_MAX_SEGMENT, $urandom_range(1, 1500));
                    reg_write(REG_INIT_TO, 32'd1000000);
                    reg_write(REG_INIT_WIN, 32'd1400);
                end
                default: ;
            endcase
            if (ph == 2) begin
                snd_idle = 72; rcv_idle = 36;
            end else if (ph == 4) begin
                snd_idle = 0; rcv_idle = 0;
            end
            if (ph == 1) hold_req = 400;
            for (int i = 0; i < 315; i++) random_req();
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fails == 0)
            $display("sliding_window_sender_tb OK");
        else
            $display("sliding_window_sender_tb NOT OK");
        $finish;
    end
endmodule
